// File: rtl/lzrle_pkg.sv
// shared constants, types and helpers for the lz/rle stream decompressor
package lzrle_pkg;

    localparam int HISTORY_DEPTH = 65536;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);

    localparam int SRC_LEN_W   = 18;
    localparam int OUT_LIM_W   = 17;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [SRC_LEN_W-1:0] SRC_LEN_RESET = '0;
    localparam logic [OUT_LIM_W-1:0] OUT_LIM_RESET = 17'h10000;

    // configuration register indexes
    localparam logic REG_SRC_LENGTH = 1'b0;
    localparam logic REG_OUT_LIMIT  = 1'b1;

    // stream status codes
    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_MARK  = 2'd1;
    localparam logic [1:0] ST_SRC   = 2'd2;
    localparam logic [1:0] ST_LIMIT = 2'd3;

    localparam logic [7:0] END_MARK = 8'hFF;

    // header op field value that selects the extended form
    localparam logic [2:0] HDR_EXT = 3'b111;

    // command operations
    typedef enum logic [2:0] {
        OP_VERBATIM,
        OP_FILL,
        OP_WORD,
        OP_INC,
        OP_BACK,
        OP_FLIP,
        OP_REVERSE,
        OP_BACK_EXT
    } op_t;

    // what the decoder hands to the output stage for one transaction
    typedef struct packed {
        logic        out_valid;
        logic [7:0]  lit_byte;
        logic        copy;
        logic        zero;
        logic        flip;
        logic [15:0] index;
        logic        byte_taken;
        logic        finished;
        logic [1:0]  status;
    } emit_t;

    function automatic logic [7:0] flip8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = b[7-i];
        end
        return r;
    endfunction

endpackage

// File: rtl/lzrle_if.sv
// valid/ready channel interfaces for command items and results
interface lzrle_item_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic       src_valid;
    logic [7:0] src_byte;

    modport source (output valid, action, src_valid, src_byte, input ready);
    modport sink   (input valid, action, src_valid, src_byte, output ready);
endinterface

interface lzrle_result_if;
    logic        valid;
    logic        ready;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [15:0] out_index;
    logic        byte_taken;
    logic        finished;
    logic [1:0]  status;

    modport source (output valid, out_valid, out_byte, out_index, byte_taken, finished,
                    status, input ready);
    modport sink   (input valid, out_valid, out_byte, out_index, byte_taken, finished,
                    status, output ready);
endinterface

// File: rtl/lzrle_cfg_regs.sv
// apb configuration registers: source length and output limit
module lzrle_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lzrle_pkg::PADDR_W-1:0]     paddr,
    input  logic [lzrle_pkg::PDATA_W-1:0]     pwdata,
    output logic [lzrle_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready,
    output logic [lzrle_pkg::SRC_LEN_W-1:0]   src_length,
    output logic [lzrle_pkg::OUT_LIM_W-1:0]   out_limit
);

    logic [lzrle_pkg::SRC_LEN_W-1:0] src_length_reg;
    logic [lzrle_pkg::OUT_LIM_W-1:0] out_limit_reg;
    logic                            wr_en;
    logic                            reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_length_reg <= lzrle_pkg::SRC_LEN_RESET;
            out_limit_reg  <= lzrle_pkg::OUT_LIM_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                lzrle_pkg::REG_SRC_LENGTH: src_length_reg <= pwdata[lzrle_pkg::SRC_LEN_W-1:0];
                lzrle_pkg::REG_OUT_LIMIT:  out_limit_reg  <= pwdata[lzrle_pkg::OUT_LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            lzrle_pkg::REG_SRC_LENGTH:
                prdata = {{(lzrle_pkg::PDATA_W-lzrle_pkg::SRC_LEN_W){1'b0}}, src_length_reg};
            lzrle_pkg::REG_OUT_LIMIT:
                prdata = {{(lzrle_pkg::PDATA_W-lzrle_pkg::OUT_LIM_W){1'b0}}, out_limit_reg};
            default:
                prdata = '0;
        endcase
    end

    assign src_length = src_length_reg;
    assign out_limit  = out_limit_reg;

endmodule

// File: rtl/lzrle_hist_ram.sv
// output history memory, one write and one registered read port
module lzrle_hist_ram (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [lzrle_pkg::HIST_AW-1:0] wr_addr,
    input  logic [7:0]                    wr_data,
    input  logic                          rd_en,
    input  logic [lzrle_pkg::HIST_AW-1:0] rd_addr,
    output logic [7:0]                    rd_data
);

    logic [7:0] mem [lzrle_pkg::HISTORY_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/lzrle_decode.sv
// command decoder: header, length and operand parsing, counters and stream end
module lzrle_decode (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              action,
    input  logic                              src_valid,
    input  logic [7:0]                        src_byte,
    input  logic [lzrle_pkg::SRC_LEN_W-1:0]   src_length,
    input  logic [lzrle_pkg::OUT_LIM_W-1:0]   out_limit,
    output lzrle_pkg::emit_t                  emit,
    output logic [lzrle_pkg::HIST_AW-1:0]     rd_addr
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_OPND1,
        PH_OPND2,
        PH_EMIT
    } phase_t;

    phase_t         phase_reg, phase_next;
    lzrle_pkg::op_t op_reg, op_next;
    logic [10:0]    rem_reg, rem_next;
    logic [7:0]     lo_reg, lo_next;
    logic [7:0]     hi_reg, hi_next;
    logic           half_reg, half_next;
    logic [16:0]    ref_reg, ref_next;
    logic [16:0]    oc_reg, oc_next;
    logic [17:0]    ic_reg, ic_next;
    logic           done_reg, done_next;
    logic [1:0]     code_reg, code_next;

    logic        src_out;
    logic        src_out2;
    logic        lim_hit;
    logic        lim_hit2;
    logic        short_code_hi;
    logic [10:0] rem_dec;
    logic        one_byte_op;

    assign src_out       = ic_reg >= src_length;
    assign src_out2      = ({1'b0, ic_reg} + 19'd1) >= {1'b0, src_length};
    assign lim_hit       = oc_reg >= out_limit;
    assign lim_hit2      = ({1'b0, oc_reg} + 18'd1) >= {1'b0, out_limit};
    assign short_code_hi = lim_hit;
    assign rem_dec       = rem_reg - 11'd1;
    assign one_byte_op   = (op_reg == lzrle_pkg::OP_FILL) || (op_reg == lzrle_pkg::OP_INC);
    assign rd_addr       = ref_reg[lzrle_pkg::HIST_AW-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        op_next    = op_reg;
        rem_next   = rem_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        half_next  = half_reg;
        ref_next   = ref_reg;
        oc_next    = oc_reg;
        ic_next    = ic_reg;
        done_next  = done_reg;
        code_next  = code_reg;

        emit            = '0;

        if (action)
        begin
            phase_next = PH_HEADER;
            op_next    = lzrle_pkg::OP_VERBATIM;
            rem_next   = '0;
            lo_next    = '0;
            hi_next    = '0;
            half_next  = 1'b0;
            ref_next   = '0;
            oc_next    = '0;
            ic_next    = '0;
            done_next  = 1'b0;
            code_next  = lzrle_pkg::ST_RUN;
        end
        else if (!done_reg)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (lim_hit || src_out)
                    begin
                        done_next = 1'b1;
                        code_next = short_code_hi ? lzrle_pkg::ST_LIMIT : lzrle_pkg::ST_SRC;
                    end
                    else if (src_valid)
                    begin
                        emit.byte_taken = 1'b1;
                        ic_next         = ic_reg + 18'd1;
                        if (src_byte == lzrle_pkg::END_MARK)
                        begin
                            done_next = 1'b1;
                            code_next = lzrle_pkg::ST_MARK;
                        end
                        else if (src_byte[7:5] == lzrle_pkg::HDR_EXT)
                        begin
                            // extended header, length continues in the next byte
                            op_next    = lzrle_pkg::op_t'(src_byte[4:2]);
                            rem_next   = {9'd0, src_byte[1:0]};
                            phase_next = PH_LENGTH;
                        end
                        else
                        begin
                            op_next    = lzrle_pkg::op_t'(src_byte[7:5]);
                            rem_next   = {6'd0, src_byte[4:0]} + 11'd1;
                            phase_next = (lzrle_pkg::op_t'(src_byte[7:5]) ==
                                          lzrle_pkg::OP_VERBATIM) ? PH_EMIT : PH_OPND1;
                            half_next  = 1'b0;
                        end
                    end
                end
                PH_LENGTH:
                begin
                    if (src_out)
                    begin
                        done_next = 1'b1;
                        code_next = short_code_hi ? lzrle_pkg::ST_LIMIT : lzrle_pkg::ST_SRC;
                    end
                    else if (src_valid)
                    begin
                        emit.byte_taken = 1'b1;
                        ic_next         = ic_reg + 18'd1;
                        rem_next        = {1'b0, rem_reg[1:0], src_byte} + 11'd1;
                        phase_next      = (op_reg == lzrle_pkg::OP_VERBATIM) ? PH_EMIT
                                                                              : PH_OPND1;
                        half_next       = 1'b0;
                    end
                end
                PH_OPND1:
                begin
                    if (one_byte_op ? src_out : src_out2)
                    begin
                        done_next = 1'b1;
                        code_next = short_code_hi ? lzrle_pkg::ST_LIMIT : lzrle_pkg::ST_SRC;
                    end
                    else if (src_valid)
                    begin
                        emit.byte_taken = 1'b1;
                        ic_next         = ic_reg + 18'd1;
                        lo_next         = src_byte;
                        phase_next      = one_byte_op ? PH_EMIT : PH_OPND2;
                    end
                end
                PH_OPND2:
                begin
                    if (src_out)
                    begin
                        done_next = 1'b1;
                        code_next = short_code_hi ? lzrle_pkg::ST_LIMIT : lzrle_pkg::ST_SRC;
                    end
                    else if (src_valid)
                    begin
                        emit.byte_taken = 1'b1;
                        ic_next         = ic_reg + 18'd1;
                        hi_next         = src_byte;
                        if (op_reg != lzrle_pkg::OP_WORD)
                        begin
                            ref_next = {1'b0, lo_reg, src_byte};
                        end
                        phase_next = PH_EMIT;
                    end
                end
                PH_EMIT:
                begin
                    if (op_reg == lzrle_pkg::OP_VERBATIM)
                    begin
                        if (lim_hit || src_out)
                        begin
                            done_next = 1'b1;
                            code_next = short_code_hi ? lzrle_pkg::ST_LIMIT
                                                      : lzrle_pkg::ST_SRC;
                        end
                        else if (src_valid)
                        begin
                            emit.byte_taken = 1'b1;
                            ic_next         = ic_reg + 18'd1;
                            emit.out_valid  = 1'b1;
                            emit.lit_byte   = src_byte;
                            emit.index      = oc_reg[15:0];
                            oc_next         = oc_reg + 17'd1;
                            rem_next        = rem_dec;
                            if (rem_dec == 11'd0)
                            begin
                                phase_next = PH_HEADER;
                            end
                        end
                    end
                    else if (op_reg == lzrle_pkg::OP_WORD)
                    begin
                        if (!half_reg)
                        begin
                            // the whole word has to fit under the limit
                            if (lim_hit2)
                            begin
                                done_next = 1'b1;
                                code_next = lzrle_pkg::ST_LIMIT;
                            end
                            else
                            begin
                                emit.out_valid = 1'b1;
                                emit.lit_byte  = lo_reg;
                                emit.index     = oc_reg[15:0];
                                oc_next        = oc_reg + 17'd1;
                                half_next      = 1'b1;
                            end
                        end
                        else
                        begin
                            emit.out_valid = 1'b1;
                            emit.lit_byte  = hi_reg;
                            emit.index     = oc_reg[15:0];
                            oc_next        = oc_reg + 17'd1;
                            half_next      = 1'b0;
                            rem_next       = rem_dec;
                            if (rem_dec == 11'd0)
                            begin
                                phase_next = PH_HEADER;
                            end
                        end
                    end
                    else if (lim_hit)
                    begin
                        done_next = 1'b1;
                        code_next = lzrle_pkg::ST_LIMIT;
                    end
                    else
                    begin
                        emit.out_valid = 1'b1;
                        emit.index     = oc_reg[15:0];
                        oc_next        = oc_reg + 17'd1;
                        rem_next       = rem_dec;
                        if (rem_dec == 11'd0)
                        begin
                            phase_next = PH_HEADER;
                        end
                        if (op_reg == lzrle_pkg::OP_FILL)
                        begin
                            emit.lit_byte = lo_reg;
                        end
                        else if (op_reg == lzrle_pkg::OP_INC)
                        begin
                            emit.lit_byte = lo_reg;
                            lo_next       = lo_reg + 8'd1;
                        end
                        else
                        begin
                            // back-copy: byte comes from history in the next stage
                            emit.copy = 1'b1;
                            emit.zero = !(ref_reg < oc_reg);
                            emit.flip = (op_reg == lzrle_pkg::OP_FLIP);
                            if (op_reg == lzrle_pkg::OP_REVERSE)
                            begin
                                if (ref_reg != 17'd0)
                                begin
                                    ref_next = ref_reg - 17'd1;
                                end
                            end
                            else
                            begin
                                ref_next = ref_reg + 17'd1;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end

        emit.finished = done_next;
        emit.status   = done_next ? code_next : lzrle_pkg::ST_RUN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            op_reg    <= lzrle_pkg::OP_VERBATIM;
            rem_reg   <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            half_reg  <= 1'b0;
            ref_reg   <= '0;
            oc_reg    <= '0;
            ic_reg    <= '0;
            done_reg  <= 1'b0;
            code_reg  <= lzrle_pkg::ST_RUN;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
            rem_reg   <= rem_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            half_reg  <= half_next;
            ref_reg   <= ref_next;
            oc_reg    <= oc_next;
            ic_reg    <= ic_next;
            done_reg  <= done_next;
            code_reg  <= code_next;
        end
    end

endmodule

// File: rtl/lz_rle_stream_decompressor_unit.sv
// Streaming LZ/RLE decompressor. One item transaction is taken per clock and its
// result appears in the output register the cycle after; with the result side ready
// the block sustains one item per cycle. The decoder updates its counters on the
// transaction, and a back-copy reads the history RAM at that same edge; the byte being
// written by the previous result in that cycle is forwarded around the RAM. History
// positions not yet produced in the current stream read as zero by a count compare,
// so the RAM needs no clearing pass after reset or at a stream start.
module lz_rle_stream_decompressor_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    lzrle_item_if.sink                        item,
    lzrle_result_if.source                    result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lzrle_pkg::PADDR_W-1:0]     paddr,
    input  logic [lzrle_pkg::PDATA_W-1:0]     pwdata,
    output logic [lzrle_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);

    logic [lzrle_pkg::SRC_LEN_W-1:0] src_length;
    logic [lzrle_pkg::OUT_LIM_W-1:0] out_limit;
    lzrle_pkg::emit_t                emit;
    lzrle_pkg::emit_t                s2_reg;
    logic                            s2_valid_reg;
    logic                            wr_pend_reg;
    logic                            fwd_hit_reg;
    logic [7:0]                      fwd_data_reg;
    logic                            accept;
    logic [lzrle_pkg::HIST_AW-1:0]   rd_addr;
    logic [lzrle_pkg::HIST_AW-1:0]   wr_addr;
    logic [7:0]                      ram_q;
    logic [7:0]                      mem_byte;
    logic [7:0]                      copy_byte;
    logic [7:0]                      res_byte;

    assign item.ready = !s2_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    lzrle_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .src_length (src_length),
        .out_limit  (out_limit)
    );

    lzrle_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .action     (item.action),
        .src_valid  (item.src_valid),
        .src_byte   (item.src_byte),
        .src_length (src_length),
        .out_limit  (out_limit),
        .emit       (emit),
        .rd_addr    (rd_addr)
    );

    assign wr_addr = s2_reg.index[lzrle_pkg::HIST_AW-1:0];

    lzrle_hist_ram u_hist (
        .clk     (clk),
        .wr_en   (wr_pend_reg),
        .wr_addr (wr_addr),
        .wr_data (res_byte),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    assign mem_byte  = fwd_hit_reg ? fwd_data_reg : ram_q;
    assign copy_byte = s2_reg.zero ? 8'd0
                                   : (s2_reg.flip ? lzrle_pkg::flip8(mem_byte) : mem_byte);
    assign res_byte  = !s2_reg.out_valid ? 8'd0
                                         : (s2_reg.copy ? copy_byte : s2_reg.lit_byte);

    // the history write happens in the first cycle a byte sits in the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            wr_pend_reg  <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= accept && emit.out_valid;
            if (accept)
            begin
                s2_valid_reg <= 1'b1;
                fwd_hit_reg  <= wr_pend_reg && (wr_addr == rd_addr);
            end
            else if (result.ready)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_reg       <= emit;
            fwd_data_reg <= res_byte;
        end
    end

    assign result.valid      = s2_valid_reg;
    assign result.out_valid  = s2_reg.out_valid;
    assign result.out_byte   = res_byte;
    assign result.out_index  = s2_reg.index;
    assign result.byte_taken = s2_reg.byte_taken;
    assign result.finished   = s2_reg.finished;
    assign result.status     = s2_reg.status;

endmodule

// File: rtl/lzrle_checker.sv
// port-level checks on the decompressor results
module lzrle_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        out_valid,
    input logic [7:0]  out_byte,
    input logic [15:0] out_index,
    input logic        finished,
    input logic [1:0]  status
);

    // an ended stream never produces a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && finished |-> !out_valid)
        else $error("byte produced after stream end");

    // status is nonzero exactly when the stream has ended
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (finished == (status != lzrle_pkg::ST_RUN)))
        else $error("status does not match finished");

    // no byte means zero byte and index fields
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |-> (out_byte == 8'd0) && (out_index == 16'd0))
        else $error("idle result carries data");

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

endmodule

bind lz_rle_stream_decompressor_unit lzrle_checker u_lzrle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .out_valid (result.out_valid),
    .out_byte  (result.out_byte),
    .out_index (result.out_index),
    .finished  (result.finished),
    .status    (result.status)
);
